// ===== design/kalsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// kalsoc_pkg
// Shared types, constants and reset values of the scalar Kalman SOC estimator.
// ----------------------------------------------------------------------------
package kalsoc_pkg;

  // Default state width (Q.28, soc signed, covariance unsigned)
  localparam int DEF_STATE_WIDTH = 32;

  // Fixed-point layout
  localparam int FRAC      = 28;
  localparam int GAIN_W    = FRAC + 1;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int VOLT_W    = 16;
  localparam int CUR_W     = 16;
  localparam int OUT_W     = 32;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHG_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SOC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV   = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_PROC_NOISE = 32'd2684355;
  localparam logic [CFG_W-1:0] RST_MEAS_NOISE = 32'd26843546;
  localparam logic [CFG_W-1:0] RST_CHG_SCALE  = 32'd10181;
  localparam logic [CFG_W-1:0] RST_VOLT_SCALE = 32'd18572832;
  localparam logic [CFG_W-1:0] RST_INIT_SOC   = 32'd134217728;
  localparam logic [CFG_W-1:0] RST_INIT_COV   = 32'd2684355;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHG,
    ST_PRED,
    ST_DEN,
    ST_DIVS,
    ST_DIVW,
    ST_GHI,
    ST_GLO,
    ST_TSUM,
    ST_CLO,
    ST_CSUM,
    ST_DONE
  } kalsoc_state_e;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MS_NONE,
    MS_CHG,
    MS_VOL,
    MS_GHI,
    MS_GLO,
    MS_CHI,
    MS_CLO
  } mul_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     ld_pred;
    logic     ld_den;
    logic     div_start;
    logic     ld_innov;
    logic     ld_acc;
    logic     ld_t;
    logic     ld_covn;
    logic     ld_socn;
    logic     commit;
    mul_sel_e mul_sel;
  } kalsoc_cmd_t;

endpackage

// ===== design/scalar_kalman_soc_estimator.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_soc_estimator
// Scalar Kalman filter estimating battery state of charge in Q4.28.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per sample: pack
//   voltage in mV and signed current in mA (positive discharges). Output
//   channel (out_valid_o / out_stall_i) returns one item per input: the prior
//   and updated SOC, the updated covariance and the gain used.
//   Work per item: the restoring gain divider, one quotient bit a cycle over
//   29 bits (skipped when covariance plus measure noise is zero), plus six
//   passes through one shared 32x32 multiplier.
//   The input stalls while an item is in work. A finished result sits in the
//   output register; the next item is accepted meanwhile, and its result waits
//   in the last step until the receiver takes the previous one.
//   Reset loads the register defaults and the state from the init_soc and
//   init_cov defaults, saturated to the state width. Write registers only while
//   the block is idle; writing init_soc or init_cov reloads that state.
// ----------------------------------------------------------------------------
module scalar_kalman_soc_estimator import kalsoc_pkg::*; #(
  parameter int STATE_WIDTH = DEF_STATE_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [VOLT_W-1:0]       voltage_mv_i,
  input  logic signed [CUR_W-1:0] current_ma_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] soc_prior_o,
  output logic signed [OUT_W-1:0] soc_estimate_o,
  output logic [OUT_W-1:0]        covariance_o,
  output logic [GAIN_W-1:0]       gain_o
);

  kalsoc_cmd_t cmd;
  logic        div_done;

  // Sequence the item: predict, divide for the gain, update, hand over
  kalsoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  // Hold registers and state, do the arithmetic
  kalsoc_dp #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .voltage_mv_i   (voltage_mv_i),
    .current_ma_i   (current_ma_i),
    .cmd_i          (cmd),
    .div_done_o     (div_done),
    .soc_prior_o    (soc_prior_o),
    .soc_estimate_o (soc_estimate_o),
    .covariance_o   (covariance_o),
    .gain_o         (gain_o)
  );

endmodule

// ===== design/kalsoc_div.sv =====
// ----------------------------------------------------------------------------
// kalsoc_div
// Iterative restoring divider for the Kalman gain, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kalsoc_div import kalsoc_pkg::*; #(
  parameter int NUM_W = DEF_STATE_WIDTH,
  parameter int DEN_W = DEF_STATE_WIDTH + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [GAIN_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(FRAC + 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [GAIN_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W-1:0]  num_x;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    num_x  = DEN_W'(num_i);
    rem_sh = {rem_q, 1'b0};
    if (start_i) begin
      den_d = den_i;
      cnt_d = CNT_W'(FRAC);
      if (den_i == '0) begin
        // zero denominator: gain is zero
        quo_d  = '0;
        rem_d  = '0;
        busy_d = 1'b0;
      end else if (num_x >= den_i) begin
        quo_d  = GAIN_W'(1);
        rem_d  = num_x - den_i;
        busy_d = 1'b1;
      end else begin
        quo_d  = '0;
        rem_d  = num_x;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DEN_W'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[GAIN_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        quo_d = {quo_q[GAIN_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = !busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/kalsoc_dp.sv =====
// ----------------------------------------------------------------------------
// kalsoc_dp
// Datapath: configuration registers, filter state, shared multiplier and gain
// divider, result registers.
// ----------------------------------------------------------------------------
module kalsoc_dp import kalsoc_pkg::*; #(
  parameter int STATE_WIDTH = DEF_STATE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic [VOLT_W-1:0]     voltage_mv_i,
  input  logic signed [CUR_W-1:0] current_ma_i,
  input  kalsoc_cmd_t           cmd_i,
  output logic                  div_done_o,
  output logic signed [OUT_W-1:0] soc_prior_o,
  output logic signed [OUT_W-1:0] soc_estimate_o,
  output logic [OUT_W-1:0]      covariance_o,
  output logic [GAIN_W-1:0]     gain_o
);

  localparam int W  = STATE_WIDTH;
  localparam int EW = ((W > 38) ? W : 38) + 3;
  localparam int XW = EW + 1;
  localparam int MW = EW - 1;
  localparam int DW = ((W > 32) ? W : 32) + 1;
  localparam int RW = 37;

  localparam longint SocHi  = (longint'(1) <<< (W - 1)) - 1;
  localparam longint SocLo  = -SocHi - 1;
  localparam longint CovHi  = (longint'(1) <<< W) - 1;
  localparam longint SocIni = longint'($signed(RST_INIT_SOC));
  localparam longint CovIni = longint'(RST_INIT_COV);
  localparam longint SocRst = (SocIni > SocHi) ? SocHi : ((SocIni < SocLo) ? SocLo : SocIni);
  localparam longint CovRst = (CovIni > CovHi) ? CovHi : CovIni;

  localparam logic signed [XW-1:0] SOC_HI_X = XW'(SocHi);
  localparam logic signed [XW-1:0] SOC_LO_X = XW'(SocLo);
  localparam logic [XW-1:0]        COV_HI_X = XW'(CovHi);

  function automatic logic signed [W-1:0] sat_s(input logic signed [XW-1:0] v);
    if (v > SOC_HI_X) begin
      sat_s = SOC_HI_X[W-1:0];
    end else if (v < SOC_LO_X) begin
      sat_s = SOC_LO_X[W-1:0];
    end else begin
      sat_s = v[W-1:0];
    end
  endfunction

  function automatic logic [W-1:0] sat_u(input logic [XW-1:0] v);
    if (v > COV_HI_X) begin
      sat_u = COV_HI_X[W-1:0];
    end else begin
      sat_u = v[W-1:0];
    end
  endfunction

  // Round a Q.40 product to Q.28, ties away from zero
  function automatic logic [RW-1:0] rnd12(input logic [47:0] m);
    logic [48:0] s;
    s = {1'b0, m} + 49'd2048;
    rnd12 = s[48:12];
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] pnoise_q, mnoise_q, cscale_q, vscale_q;

  // Filter state
  logic signed [W-1:0] soc_q;
  logic [W-1:0]        cov_q;

  // Item working registers
  logic [VOLT_W-1:0]   volt_q;
  logic [CUR_W-1:0]    cmag_q;
  logic                cneg_q;
  logic [PROD_W-1:0]   p_q;
  logic signed [W-1:0] socp_q;
  logic [W-1:0]        covp_q;
  logic [DW-1:0]       den_q;
  logic [RW-1:0]       meas_q;
  logic [MW-1:0]       imag_q;
  logic                ineg_q;
  logic [MW:0]         acc_q;
  logic [MW:0]         t_q;
  logic [MW:0]         covn_q;
  logic signed [W-1:0] socn_q;

  logic [CUR_W-1:0]    cmag_d;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [GAIN_W-1:0]   gain;
  logic [GAIN_W-1:0]   kc;
  logic [MW-1:0]       covx;
  logic [RW-1:0]       dmag;
  logic signed [XW-1:0] socp_raw, innov, socn_raw;
  logic [XW-1:0]       covp_raw;
  logic [XW-1:0]       imag_x;
  logic [57:0]         lo_sum;
  logic [MW:0]         sum_lo;

  kalsoc_div #(
    .NUM_W (W),
    .DEN_W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (covp_q),
    .den_i   (den_q),
    .done_o  (div_done_o),
    .quo_o   (gain)
  );

  assign cmag_d = current_ma_i[CUR_W-1] ? CUR_W'(-current_ma_i) : CUR_W'(current_ma_i);
  assign kc     = GAIN_ONE - gain;
  assign covx   = MW'(covp_q);

  // Operand selection of the shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MS_CHG: begin
        mul_a = MUL_W'(cmag_q);
        mul_b = cscale_q;
      end
      MS_VOL: begin
        mul_a = MUL_W'(volt_q);
        mul_b = vscale_q;
      end
      MS_GHI: begin
        mul_a = MUL_W'(gain);
        mul_b = MUL_W'(imag_q[MW-1:FRAC]);
      end
      MS_GLO: begin
        mul_a = MUL_W'(gain);
        mul_b = MUL_W'(imag_q[FRAC-1:0]);
      end
      MS_CHI: begin
        mul_a = MUL_W'(kc);
        mul_b = MUL_W'(covx[MW-1:FRAC]);
      end
      MS_CLO: begin
        mul_a = MUL_W'(kc);
        mul_b = MUL_W'(covx[FRAC-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Predict, innovation and update arithmetic
  always_comb begin
    dmag     = rnd12(p_q[47:0]);
    socp_raw = cneg_q ? (XW'(soc_q) + $signed(XW'(dmag)))
                      : (XW'(soc_q) - $signed(XW'(dmag)));
    covp_raw = XW'(cov_q) + XW'(pnoise_q);
    innov    = $signed(XW'(meas_q)) - XW'(socp_q);
    imag_x   = innov[XW-1] ? XW'(-innov) : XW'(innov);
    lo_sum   = {1'b0, p_q[56:0]} + 58'(GAIN_ONE >> 1);
    sum_lo   = acc_q + (MW+1)'(lo_sum[57:FRAC]);
    socn_raw = ineg_q ? (XW'(socp_q) - $signed(XW'(t_q)))
                      : (XW'(socp_q) + $signed(XW'(t_q)));
  end

  // Configuration registers and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnoise_q <= RST_PROC_NOISE;
      mnoise_q <= RST_MEAS_NOISE;
      cscale_q <= RST_CHG_SCALE;
      vscale_q <= RST_VOLT_SCALE;
      soc_q    <= W'(SocRst);
      cov_q    <= W'(CovRst);
    end else begin
      if (cmd_i.commit) begin
        soc_q <= socn_q;
        cov_q <= sat_u(XW'(covn_q));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROC_NOISE: pnoise_q <= cfg_wdata_i;
          REG_MEAS_NOISE: mnoise_q <= cfg_wdata_i;
          REG_CHG_SCALE:  cscale_q <= cfg_wdata_i;
          REG_VOLT_SCALE: vscale_q <= cfg_wdata_i;
          REG_INIT_SOC:   soc_q    <= sat_s(XW'($signed(cfg_wdata_i)));
          REG_INIT_COV:   cov_q    <= sat_u(XW'(cfg_wdata_i));
          default: ;
        endcase
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd_i.capture) begin
      volt_q <= voltage_mv_i;
      cmag_q <= cmag_d;
      cneg_q <= current_ma_i[CUR_W-1];
    end
    if (cmd_i.ld_pred) begin
      socp_q <= sat_s(socp_raw);
      covp_q <= sat_u(covp_raw);
    end
    if (cmd_i.ld_den) begin
      den_q  <= DW'(covp_q) + DW'(mnoise_q);
      meas_q <= rnd12(p_q[47:0]);
    end
    if (cmd_i.ld_innov) begin
      imag_q <= imag_x[MW-1:0];
      ineg_q <= innov[XW-1];
    end
    if (cmd_i.ld_acc) begin
      acc_q <= p_q[MW:0];
    end
    if (cmd_i.ld_t) begin
      t_q <= sum_lo;
    end
    if (cmd_i.ld_covn) begin
      covn_q <= sum_lo;
    end
    if (cmd_i.ld_socn) begin
      socn_q <= sat_s(socn_raw);
    end
    if (cmd_i.commit) begin
      soc_prior_o    <= OUT_W'(soc_q);
      soc_estimate_o <= OUT_W'(socn_q);
      covariance_o   <= OUT_W'(sat_u(XW'(covn_q)));
      gain_o         <= gain;
    end
  end

endmodule

// ===== design/kalsoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kalsoc_ctrl
// Controller: sequences predict, gain division and update, owns the handshakes.
// ----------------------------------------------------------------------------
module kalsoc_ctrl import kalsoc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        div_done_i,
  output kalsoc_cmd_t cmd_o
);

  kalsoc_state_e state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CHG;
      ST_CHG:  state_d = ST_PRED;
      ST_PRED: state_d = ST_DEN;
      ST_DEN:  state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: if (div_done_i) state_d = ST_GHI;
      ST_GHI:  state_d = ST_GLO;
      ST_GLO:  state_d = ST_TSUM;
      ST_TSUM: state_d = ST_CLO;
      ST_CLO:  state_d = ST_CSUM;
      ST_CSUM: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MS_NONE;
    case (state_q)
      ST_IDLE: cmd_o.capture = in_valid_i;
      ST_CHG:  cmd_o.mul_sel = MS_CHG;
      ST_PRED: begin
        cmd_o.ld_pred = 1'b1;
        cmd_o.mul_sel = MS_VOL;
      end
      ST_DEN:  cmd_o.ld_den = 1'b1;
      ST_DIVS: begin
        cmd_o.div_start = 1'b1;
        cmd_o.ld_innov  = 1'b1;
      end
      ST_DIVW: ;
      ST_GHI:  cmd_o.mul_sel = MS_GHI;
      ST_GLO: begin
        cmd_o.ld_acc  = 1'b1;
        cmd_o.mul_sel = MS_GLO;
      end
      ST_TSUM: begin
        cmd_o.ld_t    = 1'b1;
        cmd_o.mul_sel = MS_CHI;
      end
      ST_CLO: begin
        cmd_o.ld_acc  = 1'b1;
        cmd_o.mul_sel = MS_CLO;
      end
      ST_CSUM: begin
        cmd_o.ld_covn = 1'b1;
        cmd_o.ld_socn = 1'b1;
      end
      ST_DONE: cmd_o.commit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_DONE && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/tb_scalar_kalman_soc_estimator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_soc_estimator
// Self-checking bench for the scalar Kalman SOC estimator. A short table of
// samples and register writes exercises the field extremes, saturation,
// rounding ties, a zero gain denominator and unused register indexes. Random
// register settings and sample streams follow. Every result item is checked
// against an in-bench fixed-point model of the filter or against a result typed
// into its table row, with random input gaps and random output stalls.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_soc_estimator;
  import kalsoc_pkg::*;

  localparam int SW          = DEF_STATE_WIDTH;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 135;
  localparam int MAX_REPORTS = 40;
  localparam logic [63:0] Q28_ONE = 64'd1 << FRAC;

  // Indexes beyond the register file: writes there must leave everything alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [OUT_W-1:0]  prior;
    logic [OUT_W-1:0]  est;
    logic [OUT_W-1:0]  cov;
    logic [GAIN_W-1:0] gain;
  } soc_result_t;

  // Table rows: a register write, a sample checked by the model, or a sample
  // whose result is typed straight into the row
  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_FIXED} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      wdata;
    logic [VOLT_W-1:0]     volt;
    logic [CUR_W-1:0]      cur;
    soc_result_t           want;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [VOLT_W-1:0]       voltage_mv_i;
  logic signed [CUR_W-1:0] current_ma_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [OUT_W-1:0] soc_prior_o;
  logic signed [OUT_W-1:0] soc_estimate_o;
  logic [OUT_W-1:0]        covariance_o;
  logic [GAIN_W-1:0]       gain_o;

  // Model copy of the registers and the filter state
  logic [CFG_W-1:0] q_noise, r_noise, chg_scale, volt_scale;
  longint           est_soc;
  logic [63:0]      est_cov;

  // Results still owed by the block, oldest first
  soc_result_t result_q [$];
  stim_row_t   dir_tbl [$];
  int          fault_count = 0;

  scalar_kalman_soc_estimator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .voltage_mv_i   (voltage_mv_i),
    .current_ma_i   (current_ma_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .soc_prior_o    (soc_prior_o),
    .soc_estimate_o (soc_estimate_o),
    .covariance_o   (covariance_o),
    .gain_o         (gain_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point model
  // --------------------------------------------------------------------------
  function automatic longint clamp_soc(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (SW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [63:0] clamp_cov(input logic [63:0] v);
    logic [63:0] hi;
    hi = (64'd1 << SW) - 64'd1;
    return (v > hi) ? hi : v;
  endfunction

  // Q.40 magnitude to Q.28, halves rounded away from zero
  function automatic logic [63:0] round_q40(input logic [63:0] m);
    return (m + 64'd2048) >> 12;
  endfunction

  // k * m / 2^28 rounded, split so that nothing overflows 64 bits
  function automatic logic [63:0] mul_q28(input logic [63:0] k, input logic [63:0] m);
    logic [63:0] hi, lo;
    hi = m >> FRAC;
    lo = m & (Q28_ONE - 64'd1);
    return k * hi + ((k * lo + (Q28_ONE >> 1)) >> FRAC);
  endfunction

  // One predict/update pass; advances the model state and returns the result
  function automatic soc_result_t filter_step(input logic [VOLT_W-1:0] volt,
                                              input logic [CUR_W-1:0] cur);
    logic [63:0] cmag, dmag, covp, den, rem, g, imag, t, covn;
    longint      prior, socp, meas, innov, socn;
    soc_result_t res;
    prior = est_soc;

    // Predict: discharge (positive current) lowers the estimate
    cmag = cur[CUR_W-1] ? 64'h1_0000 - 64'(cur) : 64'(cur);
    dmag = round_q40(cmag * 64'(chg_scale));
    socp = cur[CUR_W-1] ? clamp_soc(prior + longint'(dmag))
                        : clamp_soc(prior - longint'(dmag));
    covp = clamp_cov(est_cov + 64'(q_noise));

    // Gain covp / (covp + r), truncated; zero when the denominator is zero
    den = covp + 64'(r_noise);
    g   = '0;
    rem = covp;
    if (den != 64'd0) begin
      if (covp >= den) begin
        g   = 64'd1;
        rem = covp - den;
      end
      for (int i = 0; i < FRAC; i++) begin
        rem = rem << 1;
        g   = g << 1;
        if (rem >= den) begin
          rem = rem - den;
          g   = g | 64'd1;
        end
      end
    end

    // Update towards the voltage-derived SOC
    meas  = longint'(round_q40(64'(volt) * 64'(volt_scale)));
    innov = meas - socp;
    imag  = (innov < 0) ? 64'(-innov) : 64'(innov);
    t     = mul_q28(g, imag);
    socn  = (innov < 0) ? clamp_soc(socp - longint'(t)) : clamp_soc(socp + longint'(t));
    covn  = clamp_cov(mul_q28(Q28_ONE - g, covp));

    est_soc = socn;
    est_cov = covn;

    res.prior = prior[OUT_W-1:0];
    res.est   = socn[OUT_W-1:0];
    res.cov   = covn[OUT_W-1:0];
    res.gain  = g[GAIN_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Table rows
  // --------------------------------------------------------------------------
  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.wdata = data;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [VOLT_W-1:0] v,
                                         input logic [CUR_W-1:0] c);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.volt = v;
    r.cur  = c;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input logic [VOLT_W-1:0] v,
                                          input logic [CUR_W-1:0] c,
                                          input logic [OUT_W-1:0] p,
                                          input logic [OUT_W-1:0] e,
                                          input logic [OUT_W-1:0] cv,
                                          input logic [GAIN_W-1:0] g);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_FIXED;
    r.volt       = v;
    r.cur        = c;
    r.want.prior = p;
    r.want.est   = e;
    r.want.cov   = cv;
    r.want.gain  = g;
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 6);
    return $urandom_range(20, 150);
  endfunction

  // --------------------------------------------------------------------------
  // Channel and register drivers (drive on the falling edge)
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    // Mirror the write into the model; the init registers reload the state
    case (idx)
      REG_PROC_NOISE: q_noise    = data;
      REG_MEAS_NOISE: r_noise    = data;
      REG_CHG_SCALE:  chg_scale  = data;
      REG_VOLT_SCALE: volt_scale = data;
      REG_INIT_SOC:   est_soc    = clamp_soc(longint'(signed'(data)));
      REG_INIT_COV:   est_cov    = clamp_cov(64'(data));
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one sample, hold it until accepted, then queue what it should yield
  task automatic send_sample(input logic [VOLT_W-1:0] v, input logic [CUR_W-1:0] c,
                             input bit fixed, input soc_result_t want, input bit eager);
    int unsigned gap;
    soc_result_t pred;
    gap = eager ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    voltage_mv_i = v;
    current_ma_i = c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // The model always advances; typed rows replace only the expectation
    pred = filter_step(v, c);
    result_q.push_back(fixed ? want : pred);
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result checking (sample on the rising edge)
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    soc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none got %h %h %h %h", $realtime,
                   soc_prior_o, soc_estimate_o, covariance_o, gain_o);
      end else begin
        want = result_q.pop_front();
        check_field("soc_prior", want.prior, soc_prior_o);
        check_field("soc_estimate", want.est, soc_estimate_o);
        check_field("covariance", want.cov, covariance_o);
        check_field("gain", 32'(want.gain), 32'(gain_o));
      end
    end
  end

  // Receiver: free-running stretches broken by stalls of random length
  initial begin
    int unsigned run, hold;
    out_stall_i = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 60);
      repeat (run) @(negedge clk_i);
      hold = idle_len();
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t        row;
    logic [CFG_W-1:0] val, dflt;
    int unsigned      mode;
    logic [VOLT_W-1:0] v;
    logic [CUR_W-1:0]  c;
    bit               eager;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    voltage_mv_i = '0;
    current_ma_i = '0;

    q_noise    = RST_PROC_NOISE;
    r_noise    = RST_MEAS_NOISE;
    chg_scale  = RST_CHG_SCALE;
    volt_scale = RST_VOLT_SCALE;
    est_soc    = clamp_soc(longint'(signed'(RST_INIT_SOC)));
    est_cov    = clamp_cov(64'(RST_INIT_COV));

    dir_tbl = '{
      // Reset settings: rest, then every corner of voltage and current
      item_row(16'd29600, 16'h0000),
      item_row(16'd0,     16'h0000),
      item_row(16'hFFFF,  16'h7FFF),
      item_row(16'hFFFF,  16'h8000),
      item_row(16'd0,     16'h8000),
      item_row(16'd0,     16'h7FFF),
      // Charge products landing exactly on a half LSB, both signs
      cfg_row(REG_CHG_SCALE, 32'd2048),
      item_row(16'd29600, 16'h0001),
      item_row(16'd29600, 16'hFFFF),
      item_row(16'd29600, 16'h0003),
      // Everything at full scale: covariance and estimate saturate
      cfg_row(REG_PROC_NOISE, 32'hFFFF_FFFF),
      cfg_row(REG_MEAS_NOISE, 32'hFFFF_FFFF),
      cfg_row(REG_CHG_SCALE,  32'hFFFF_FFFF),
      cfg_row(REG_VOLT_SCALE, 32'hFFFF_FFFF),
      cfg_row(REG_INIT_SOC,   32'h7FFF_FFFF),
      cfg_row(REG_INIT_COV,   32'hFFFF_FFFF),
      item_row(16'hFFFF,  16'h8000),
      item_row(16'hFFFF,  16'h7FFF),
      item_row(16'd0,     16'h7FFF),
      item_row(16'd0,     16'h8000),
      cfg_row(REG_INIT_SOC,   32'h8000_0000),
      item_row(16'd0,     16'h7FFF),
      item_row(16'hFFFF,  16'h8000),
      // Unused indexes must change nothing
      cfg_row(REG_SPARE_A, 32'hFFFF_FFFF),
      cfg_row(REG_SPARE_B, 32'h0000_0000),
      item_row(16'd30000, 16'd100),
      // All noise and scales zero: denominator zero, gain zero, state held
      cfg_row(REG_PROC_NOISE, 32'd0),
      cfg_row(REG_MEAS_NOISE, 32'd0),
      cfg_row(REG_CHG_SCALE,  32'd0),
      cfg_row(REG_VOLT_SCALE, 32'd0),
      cfg_row(REG_INIT_SOC,   32'h1234_5678),
      cfg_row(REG_INIT_COV,   32'd0),
      fixed_row(16'd40000, 16'h7FFF, 32'h1234_5678, 32'h1234_5678, 32'd0, '0),
      fixed_row(16'd0,     16'h8000, 32'h1234_5678, 32'h1234_5678, 32'd0, '0),
      // Tiny covariance and no measurement noise: unit gain pulls SOC to zero
      cfg_row(REG_INIT_COV,   32'd1),
      fixed_row(16'hFFFF,  16'hFFFF, 32'h1234_5678, 32'd0, 32'd0, GAIN_ONE),
      fixed_row(16'd123,   16'h0005, 32'd0, 32'd0, 32'd0, '0),
      // Most negative starting SOC held through a zero-gain pass
      cfg_row(REG_INIT_SOC,   32'h8000_0000),
      cfg_row(REG_INIT_COV,   32'd0),
      fixed_row(16'd1,     16'h0001, 32'h8000_0000, 32'h8000_0000, 32'd0, '0)
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the table; registers change only once the block has gone idle
    foreach (dir_tbl[k]) begin
      row = dir_tbl[k];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.wdata);
      end else begin
        send_sample(row.volt, row.cur, row.kind == ROW_FIXED, row.want, 1'b0);
      end
    end

    // Random phases: new register settings, then a stream of samples
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      for (int ri = REG_PROC_NOISE; ri <= REG_INIT_COV; ri++) begin
        if ($urandom_range(0, 9) < 7) begin
          // Plausible battery settings most of the time, corners now and then
          case (CFG_IDX_W'(ri))
            REG_PROC_NOISE: begin
              dflt = RST_PROC_NOISE;
              val  = $urandom_range(0, 32'h0400_0000);
            end
            REG_MEAS_NOISE: begin
              dflt = RST_MEAS_NOISE;
              val  = $urandom_range(1, 32'h1000_0000);
            end
            REG_CHG_SCALE: begin
              dflt = RST_CHG_SCALE;
              val  = $urandom_range(0, 32'h0001_0000);
            end
            REG_VOLT_SCALE: begin
              dflt = RST_VOLT_SCALE;
              val  = $urandom_range(32'h0080_0000, 32'h0200_0000);
            end
            REG_INIT_SOC: begin
              dflt = RST_INIT_SOC;
              val  = $urandom_range(0, 32'h1000_0000);
            end
            default: begin
              dflt = RST_INIT_COV;
              val  = $urandom_range(0, 32'h0800_0000);
            end
          endcase
          mode = $urandom_range(0, 19);
          if (mode == 0)      val = '0;
          else if (mode == 1) val = '1;
          else if (mode < 4)  val = $urandom();
          else if (mode < 8)  val = dflt;
          write_reg(CFG_IDX_W'(ri), val);
        end
      end

      // Some phases run back to back with no gaps at all
      eager = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          v = $urandom_range(20000, 40000);
          c = CUR_W'($urandom_range(0, 10000) - 5000);
        end else begin
          v = $urandom();
          c = $urandom();
        end
        send_sample(v, c, 1'b0, '0, eager);
      end
    end

    settle();
    repeat (60) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("[scalar_kalman_soc_estimator] OK");
    end else begin
      $display("[scalar_kalman_soc_estimator] ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #25_000_000;
    $display("[scalar_kalman_soc_estimator] ERROR");
    $finish;
  end

endmodule
